>>> rtl/accm_pkg.sv
// Shared types, widths and arithmetic helpers for the accelerometer magnitude unit.
// No dependencies; used by the top level and accm_sqrt_pipe under rtl, and by the bench.
package accm_pkg;

    localparam int AxisW        = 14;   // raw axis code
    localparam int MagW         = 11;   // clamped magnitude divided by four
    localparam int SqW          = 2 * MagW;
    localparam int SumW         = SqW;  // three squares of at most 2**20 fit in 22 bits
    localparam int RootW        = SumW / 2;
    localparam int RemW         = RootW + 1;
    localparam int SqrtSteps    = RootW;
    localparam int StepsPerStage = 2;
    localparam int SqrtStages   = (SqrtSteps + StepsPerStage - 1) / StepsPerStage;

    localparam logic [AxisW-1:0] PosClamp = 14'h0FFF;
    localparam logic [AxisW-1:0] NegClamp = 14'h3001;

    typedef logic [AxisW-1:0] t_axis;
    typedef logic [MagW-1:0]  t_mag;
    typedef logic [SqW-1:0]   t_sq;
    typedef logic [SumW-1:0]  t_sum;
    typedef logic [RootW-1:0] t_root;

    // partial state of the digit-by-digit root
    typedef struct packed {
        logic [RemW-1:0] rem;
        t_root           root;
        t_sum            rad;
    } t_sqrt_state;

    // clamp to +/-1 g, take magnitude, divide by four
    function automatic t_mag axis_mag(input t_axis code);
        t_axis      c;
        logic [12:0] m;
        c = code;
        if (!c[13]) begin
            if (c[12]) c = PosClamp;
            m = c[12:0];
        end else begin
            if (!c[12]) c = NegClamp;
            m = 13'(~c[12:0] + 13'd1);
        end
        return m[12:2];
    endfunction

    // one restoring root step: consumes the top two radicand bits
    function automatic t_sqrt_state sqrt_step(input t_sqrt_state s);
        t_sqrt_state     n;
        logic [RemW+1:0] rem_sh;
        logic [RemW+1:0] trial;
        logic            ge;
        rem_sh  = {s.rem, s.rad[SumW-1 -: 2]};
        trial   = {1'b0, s.root, 2'b01};
        ge      = (rem_sh >= trial);
        n.rem   = ge ? RemW'(rem_sh - trial) : RemW'(rem_sh);
        n.root  = {s.root[RootW-2:0], ge};
        n.rad   = {s.rad[SumW-3:0], 2'b00};
        return n;
    endfunction

endpackage

>>> rtl/accel_clamp_vector_magnitude_unit.sv
// Top level of the accelerometer vector magnitude unit.
// Depends on accm_pkg and accm_sqrt_pipe.
//
// Usage
//   Input channel: i_valid / o_ready carry one request of three raw 14-bit
//   two's-complement axis codes (i_accel_x, i_accel_y, i_accel_z).
//   Output channel: o_valid / i_ready carry o_magnitude, the floor square
//   root of the summed squares of the clamped, quartered axis magnitudes.
//   Each code is clamped to +/-1 g, so the result never exceeds 1773.
//   Pipeline stages: magnitude, square, sum, then six root stages of two
//   result bits each (one in the last).
//   Throughput: one request per cycle while i_ready does not stall the
//   output; every stage is a register with its own valid bit.
//   Stalls: when i_ready is low the last stage holds; earlier stages keep
//   moving until they meet a full stage, so empty slots are squeezed out
//   and o_ready only drops once every stage holds a request.
//   Reset (synchronous, active low) clears all valid bits; no data held
//   in flight survives it. There is no configuration state.
module accel_clamp_vector_magnitude_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [13:0] i_accel_x,
    input  logic [13:0] i_accel_y,
    input  logic [13:0] i_accel_z,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [10:0] o_magnitude
);

    // stage 1: clamp and magnitude per axis
    logic            r_s1_vld;
    accm_pkg::t_mag  r_mx, r_my, r_mz;
    // stage 2: squares
    logic            r_s2_vld;
    accm_pkg::t_sq   r_qx, r_qy, r_qz;
    // stage 3: sum of squares
    logic            r_s3_vld;
    accm_pkg::t_sum  r_sum;

    logic w_s1_rdy, w_s2_rdy, w_s3_rdy, w_rt_rdy;

    // ready ripples back: a stage loads when empty or when its successor loads
    assign w_s3_rdy = ~r_s3_vld | w_rt_rdy;
    assign w_s2_rdy = ~r_s2_vld | w_s3_rdy;
    assign w_s1_rdy = ~r_s1_vld | w_s2_rdy;
    assign o_ready  = w_s1_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
        end else begin
            if (w_s1_rdy) r_s1_vld <= i_valid;
            if (w_s2_rdy) r_s2_vld <= r_s1_vld;
            if (w_s3_rdy) r_s3_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_rdy && i_valid) begin
            r_mx <= accm_pkg::axis_mag(i_accel_x);
            r_my <= accm_pkg::axis_mag(i_accel_y);
            r_mz <= accm_pkg::axis_mag(i_accel_z);
        end
        if (w_s2_rdy && r_s1_vld) begin
            r_qx <= accm_pkg::t_sq'(r_mx) * accm_pkg::t_sq'(r_mx);
            r_qy <= accm_pkg::t_sq'(r_my) * accm_pkg::t_sq'(r_my);
            r_qz <= accm_pkg::t_sq'(r_mz) * accm_pkg::t_sq'(r_mz);
        end
        if (w_s3_rdy && r_s2_vld) begin
            // cannot overflow: each square is at most 2**20
            r_sum <= r_qx + r_qy + r_qz;
        end
    end

    accm_sqrt_pipe u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s3_vld),
        .o_ready (w_rt_rdy),
        .i_sum   (r_sum),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_root  (o_magnitude)
    );

endmodule

>>> rtl/accm_sqrt_pipe.sv
// Pipelined floor integer square root, two result bits per register stage (one in the last).
// Depends on accm_pkg.
module accm_sqrt_pipe (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  accm_pkg::t_sum      i_sum,
    output logic                o_valid,
    input  logic                i_ready,
    output accm_pkg::t_root     o_root
);

    localparam int NStg = accm_pkg::SqrtStages;

    logic [NStg-1:0]       r_vld;
    accm_pkg::t_sqrt_state r_st [NStg];
    logic [NStg-1:0]       w_rdy;

    assign w_rdy[NStg-1] = ~r_vld[NStg-1] | i_ready;

    genvar s;
    generate
        for (s = 0; s < NStg; s++) begin : g_stg
            logic                  w_vin;
            accm_pkg::t_sqrt_state w_sin;
            accm_pkg::t_sqrt_state n_st;

            if (s < NStg - 1) begin : g_rdy
                assign w_rdy[s] = ~r_vld[s] | w_rdy[s+1];
            end

            if (s == 0) begin : g_first
                assign w_vin = i_valid;
                always_comb begin
                    w_sin.rem  = '0;
                    w_sin.root = '0;
                    w_sin.rad  = i_sum;
                end
            end else begin : g_next
                assign w_vin = r_vld[s-1];
                assign w_sin = r_st[s-1];
            end

            always_comb begin
                n_st = w_sin;
                for (int j = 0; j < accm_pkg::StepsPerStage; j++) begin
                    if (s * accm_pkg::StepsPerStage + j < accm_pkg::SqrtSteps) begin
                        n_st = accm_pkg::sqrt_step(n_st);
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[s] <= 1'b0;
                end else if (w_rdy[s]) begin
                    r_vld[s] <= w_vin;
                end
            end

            always_ff @(posedge i_clk) begin
                if (w_rdy[s] && w_vin) begin
                    r_st[s] <= n_st;
                end
            end
        end
    endgenerate

    assign o_ready = w_rdy[0];
    assign o_valid = r_vld[NStg-1];
    assign o_root  = r_st[NStg-1].root;

endmodule

>>> rtl/accm_checker.sv
// Port-level checks for the accelerometer magnitude unit, bound to the top level.
// Depends on accel_clamp_vector_magnitude_unit.
module accm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic [13:0] i_accel_x,
    input logic [13:0] i_accel_y,
    input logic [13:0] i_accel_z,
    input logic        o_valid,
    input logic        i_ready,
    input logic [10:0] o_magnitude
);

    // an offered request stays put until taken
    a_req_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_ready |=> i_valid && $stable({i_accel_x, i_accel_y, i_accel_z}))
        else $error("request changed before acceptance");

    // a held result stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_magnitude))
        else $error("result changed while stalled");

    // clamping bounds the root
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_magnitude <= 11'd1773)
        else $error("magnitude out of range");

    // an empty or draining output slot must open the input
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ready || !o_valid) |-> o_ready)
        else $error("input blocked with free output slot");

    // reset flushes everything in flight
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result survived reset");

endmodule

bind accel_clamp_vector_magnitude_unit accm_checker u_accm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_ready     (o_ready),
    .i_accel_x   (i_accel_x),
    .i_accel_y   (i_accel_y),
    .i_accel_z   (i_accel_z),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_magnitude (o_magnitude)
);

>>> tb/tb_accel_clamp_vector_magnitude_unit.sv
// Self-checking bench for the accelerometer vector magnitude unit.
// Needs accm_pkg and the unit's RTL only; predicts each magnitude on its own.
`timescale 1ns / 1ps

module tb_accel_clamp_vector_magnitude_unit;

    // Expected magnitudes in request order, worked out from the raw codes.
    class magnitude_scoreboard;
        accm_pkg::t_mag expected_mags[$];
        int unsigned    failures = 0;

        // clamp to +/-1 g in signed terms, then |v| / 4
        function int quartered_mag(accm_pkg::t_axis code);
            int v;
            v = int'(signed'(code));
            if (v > 4095) begin
                v = 4095;
            end else if (v < -4096) begin
                v = -4095;
            end
            if (v < 0) begin
                v = -v;
            end
            return v / 4;
        endfunction

        // bitwise search for the largest root whose square fits
        function int floor_root(int unsigned sum);
            int unsigned r;
            int unsigned t;
            r = 0;
            for (int b = 10; b >= 0; b--) begin
                t = r | (32'd1 << b);
                if (t * t <= sum) begin
                    r = t;
                end
            end
            return int'(r);
        endfunction

        function void note_request(accm_pkg::t_axis x, accm_pkg::t_axis y,
                                   accm_pkg::t_axis z);
            int unsigned sum;
            int          mx, my, mz;
            mx  = quartered_mag(x);
            my  = quartered_mag(y);
            mz  = quartered_mag(z);
            sum = mx * mx + my * my + mz * mz;
            expected_mags.push_back(accm_pkg::t_mag'(floor_root(sum)));
        endfunction

        function void check_magnitude(accm_pkg::t_mag got);
            accm_pkg::t_mag want;
            if (expected_mags.size() == 0) begin
                $display("%0t: magnitude with no request pending: expected none, got %0d",
                         $time, got);
                failures++;
                return;
            end
            want = expected_mags.pop_front();
            if (got !== want) begin
                $display("%0t: magnitude mismatch: expected %0d, got %0d", $time, want, got);
                failures++;
            end
        endfunction
    endclass

    localparam int RandomRequests = 1500;
    localparam int HoldStart      = 400;   // receiver cycle at which the long stall begins
    localparam int HoldCycles     = 120;
    localparam int FullRateLo     = 900;   // random requests sent with no idling on either side
    localparam int FullRateHi     = 1200;
    localparam int DrainCycles    = 30;    // well past the pipeline latency

    // Directed requests: sign/clamp boundaries on each axis, the all-most-negative
    // case giving the largest result, minus one, and values that quarter to zero.
    localparam int NumDirected = 20;
    localparam accm_pkg::t_axis DirX [NumDirected] = '{
        14'h0000, 14'h0FFF, 14'h1000, 14'h1FFF, 14'h2000, 14'h2FFF, 14'h3000,
        14'h3001, 14'h3FFF, 14'h0003, 14'h0000, 14'h0000, 14'h0FFF, 14'h1000,
        14'h3FFC, 14'h2AAA, 14'h0155, 14'h3000, 14'h1FFF, 14'h2000};
    localparam accm_pkg::t_axis DirY [NumDirected] = '{
        14'h0000, 14'h0000, 14'h0000, 14'h1FFF, 14'h0000, 14'h2FFF, 14'h3000,
        14'h3001, 14'h3FFF, 14'h0004, 14'h3000, 14'h0000, 14'h0FFF, 14'h2000,
        14'h0004, 14'h1555, 14'h3EAB, 14'h1FFF, 14'h2000, 14'h3000};
    localparam accm_pkg::t_axis DirZ [NumDirected] = '{
        14'h0000, 14'h0000, 14'h0000, 14'h1FFF, 14'h0000, 14'h2FFF, 14'h3000,
        14'h3001, 14'h3FFF, 14'h0007, 14'h0000, 14'h1000, 14'h0FFF, 14'h3000,
        14'h2FFF, 14'h0AAA, 14'h2001, 14'h2000, 14'h3000, 14'h1FFF};

    // codes either side of each clamp and sign boundary
    localparam int NumEdges = 10;
    localparam accm_pkg::t_axis EdgeCodes [NumEdges] = '{
        14'h0000, 14'h0FFF, 14'h1000, 14'h1FFF, 14'h2000,
        14'h2FFF, 14'h3000, 14'h3001, 14'h3FFF, 14'h0004};

    logic            i_clk;
    logic            i_rst_n     = 1'b0;
    logic            i_valid     = 1'b0;
    logic            i_ready     = 1'b0;
    accm_pkg::t_axis i_accel_x   = '0;
    accm_pkg::t_axis i_accel_y   = '0;
    accm_pkg::t_axis i_accel_z   = '0;
    logic            o_ready;
    logic            o_valid;
    accm_pkg::t_mag  o_magnitude;

    // Set by the sender; while high neither side idles.
    logic  full_rate = 1'b0;

    magnitude_scoreboard sb = new;

    accel_clamp_vector_magnitude_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_accel_x   (i_accel_x),
        .i_accel_y   (i_accel_y),
        .i_accel_z   (i_accel_z),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_magnitude (o_magnitude)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Offer one request and hold it until the unit takes it. Random idle cycles
    // go in front of the request, so valid only drops between requests and is
    // never lowered and raised within the same step.
    task automatic send_request(input accm_pkg::t_axis x, input accm_pkg::t_axis y,
                                input accm_pkg::t_axis z);
        while (!full_rate && $urandom_range(99) < 38) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_accel_x <= x;
        i_accel_y <= y;
        i_accel_z <= z;
        do @(posedge i_clk); while (!o_ready);
        sb.note_request(x, y, z);
    endtask

    // Uniform codes in four picks of ten (these toggle every bit), plus boundary codes with
    // a small offset, in-range codes that escape the clamp, and clamped codes.
    function automatic accm_pkg::t_axis pick_code();
        int              mode;
        accm_pkg::t_axis c;
        mode = $urandom_range(9);
        if (mode < 4) begin
            c = accm_pkg::t_axis'($urandom);
        end else if (mode < 6) begin
            c = EdgeCodes[$urandom_range(NumEdges - 1)]
                + accm_pkg::t_axis'($urandom_range(6)) - 14'd3;
        end else if (mode < 8) begin
            // positive below 1 g, or negative down to the most negative unclamped code
            c = $urandom_range(1) ? accm_pkg::t_axis'($urandom_range(14'h0FFF))
                                  : accm_pkg::t_axis'($urandom_range(14'h3FFF, 14'h3000));
        end else begin
            c = $urandom_range(1) ? accm_pkg::t_axis'($urandom_range(14'h1FFF, 14'h1000))
                                  : accm_pkg::t_axis'($urandom_range(14'h2FFF, 14'h2000));
        end
        return c;
    endfunction

    // Sender: reset, directed requests, random requests, then drain and verdict.
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < NumDirected; i++) begin
            send_request(DirX[i], DirY[i], DirZ[i]);
        end

        for (int i = 0; i < RandomRequests; i++) begin
            full_rate = (i >= FullRateLo && i < FullRateHi);
            send_request(pick_code(), pick_code(), pick_code());
        end
        full_rate = 1'b0;
        i_valid <= 1'b0;

        // every request answered, then a margin to catch any spurious result
        while (sb.expected_mags.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DrainCycles) @(posedge i_clk);

        if (sb.failures == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Receiver: random back-pressure, one long stall counted here so the
    // pipeline fills and o_ready drops, and full rate while the sender asks.
    initial begin
        int unsigned cyc;
        cyc = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n) begin
                cyc++;
            end
            if (cyc >= HoldStart && cyc < HoldStart + HoldCycles) begin
                i_ready <= 1'b0;
            end else if (full_rate) begin
                i_ready <= 1'b1;
            end else begin
                i_ready <= ($urandom_range(99) >= 38);
            end
        end
    end

    // Results are taken on the same edge the unit sees the handshake.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            sb.check_magnitude(o_magnitude);
        end
    end

    // Safety net: far beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
